### hdl/stt_pkg.sv
// Shared types, codes and character helpers for the source text tokenizer.
package stt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_SLASH     = 3'd1,
        MODE_LINE_CMT  = 3'd2,
        MODE_BLOCK_CMT = 3'd3,
        MODE_WORD      = 3'd4,
        MODE_QUOTE     = 3'd5,
        MODE_ERROR     = 3'd6
    } scan_mode_t;

    localparam logic [1:0] EV_TEXT  = 2'd0;
    localparam logic [1:0] EV_DONE  = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    localparam logic [4:0] TT_NONE   = 5'd0;
    localparam logic [4:0] TT_SLASH  = 5'd3;
    localparam logic [4:0] TT_INT    = 5'd19;
    localparam logic [4:0] TT_IDENT  = 5'd20;
    localparam logic [4:0] TT_STRING = 5'd21;
    localparam logic [4:0] TT_CHAR   = 5'd22;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Fixed-width part of one result; position fields follow it in a slot.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [4:0] ttype;
    } res_head_t;

    localparam int HEAD_BITS = $bits(res_head_t);

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } punct_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    function automatic punct_t punct_lookup(input logic [7:0] b);
        punct_t r;
        r.hit = 1'b1;
        case (b)
            8'h2B:   r.idx = 5'd0;   // +
            8'h2D:   r.idx = 5'd1;   // -
            8'h2A:   r.idx = 5'd2;   // *
            8'h2F:   r.idx = 5'd3;   // /
            8'h25:   r.idx = 5'd4;   // %
            8'h7C:   r.idx = 5'd5;   // |
            8'h26:   r.idx = 5'd6;   // &
            8'h3E:   r.idx = 5'd7;   // >
            8'h3C:   r.idx = 5'd8;   // <
            8'h3D:   r.idx = 5'd9;   // =
            8'h28:   r.idx = 5'd10;  // (
            8'h29:   r.idx = 5'd11;  // )
            8'h7B:   r.idx = 5'd12;  // {
            8'h7D:   r.idx = 5'd13;  // }
            8'h5B:   r.idx = 5'd14;  // [
            8'h5D:   r.idx = 5'd15;  // ]
            8'h3B:   r.idx = 5'd16;  // ;
            8'h21:   r.idx = 5'd17;  // !
            8'h2C:   r.idx = 5'd18;  // ,
            default:
            begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) || (b == CH_VT) ||
               (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

### hdl/stt_front.sv
// Front: one byte per unstalled cycle; updates scan state, builds a result bundle.
module stt_front #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16,
    parameter int SLOT_BITS   = stt_pkg::HEAD_BITS + LINE_BITS + COLUMN_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   text_valid,
    input  logic [7:0]             text_byte,
    output logic                   text_stall,
    output logic                   push_valid,
    output logic [2*SLOT_BITS:0]   push_data,
    input  stt_pkg::q_status_t     q_status
);

    stt_pkg::scan_mode_t    mode_reg, mode_next;
    logic                   star_reg, star_next;
    logic                   single_reg, single_next;
    logic                   digits_reg, digits_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] tok_col_reg, tok_col_next;

    stt_pkg::res_head_t     h0, h1;
    logic [LINE_BITS-1:0]   l0, l1;
    logic [COLUMN_BITS-1:0] c0, c1;
    logic                   e0_v, e1_v;

    logic                   accept;
    logic [LINE_BITS-1:0]   line_inc;
    logic [COLUMN_BITS-1:0] col_inc;

    assign text_stall = q_status.full;
    assign accept     = text_valid && !text_stall;
    assign line_inc   = (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);
    assign col_inc    = (col_reg == '1) ? col_reg : col_reg + COLUMN_BITS'(1);

    always_comb
    begin
        logic           b_nul;
        logic           b_nl;
        logic           b_quote;
        logic           b_digit;
        logic           b_close;
        logic           do_idle;
        logic [4:0]     q_type;
        stt_pkg::punct_t pn;

        b_nul   = (text_byte == stt_pkg::CH_NUL);
        b_nl    = (text_byte == stt_pkg::CH_NL);
        b_quote = (text_byte == stt_pkg::CH_SQUOTE) || (text_byte == stt_pkg::CH_DQUOTE);
        b_digit = (text_byte >= stt_pkg::CH_ZERO) && (text_byte <= stt_pkg::CH_NINE);
        b_close = single_reg ? (text_byte == stt_pkg::CH_SQUOTE)
                             : (text_byte == stt_pkg::CH_DQUOTE);
        q_type  = single_reg ? stt_pkg::TT_CHAR : stt_pkg::TT_STRING;
        pn      = stt_pkg::punct_lookup(text_byte);
        do_idle = 1'b0;

        mode_next     = mode_reg;
        star_next     = star_reg;
        single_next   = single_reg;
        digits_next   = digits_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;

        e0_v = 1'b0;
        e1_v = 1'b0;
        h0   = '0;
        h1   = '0;
        l0   = tok_line_reg;
        l1   = tok_line_reg;
        c0   = tok_col_reg;
        c1   = tok_col_reg;

        case (mode_reg)
            stt_pkg::MODE_IDLE:
            begin
                do_idle = 1'b1;
            end
            stt_pkg::MODE_SLASH:
            begin
                if (text_byte == stt_pkg::CH_SLASH)
                begin
                    mode_next = stt_pkg::MODE_LINE_CMT;
                    col_next  = col_inc;
                end
                else if (text_byte == stt_pkg::CH_STAR)
                begin
                    mode_next = stt_pkg::MODE_BLOCK_CMT;
                    star_next = 1'b1;
                    col_next  = col_inc;
                end
                else
                begin
                    e0_v      = 1'b1;
                    h0        = '{stt_pkg::EV_DONE, stt_pkg::CH_SLASH, stt_pkg::TT_SLASH};
                    mode_next = stt_pkg::MODE_IDLE;
                    do_idle   = 1'b1;
                end
            end
            stt_pkg::MODE_LINE_CMT:
            begin
                if (b_nul)
                begin
                    do_idle = 1'b1;
                end
                else if (b_nl)
                begin
                    line_next = line_inc;
                    col_next  = '0;
                    mode_next = stt_pkg::MODE_IDLE;
                end
                else
                begin
                    col_next = col_inc;
                end
            end
            stt_pkg::MODE_BLOCK_CMT:
            begin
                if (b_nul)
                begin
                    do_idle = 1'b1;
                end
                else if ((text_byte == stt_pkg::CH_SLASH) && star_reg)
                begin
                    col_next  = col_inc;
                    star_next = 1'b0;
                    mode_next = stt_pkg::MODE_IDLE;
                end
                else if (b_nl)
                begin
                    line_next = line_inc;
                    col_next  = '0;
                    star_next = 1'b0;
                end
                else
                begin
                    star_next = (text_byte == stt_pkg::CH_STAR);
                    col_next  = col_inc;
                end
            end
            stt_pkg::MODE_WORD:
            begin
                if (b_nul || stt_pkg::is_space(text_byte) || pn.hit || b_quote)
                begin
                    e0_v        = 1'b1;
                    h0          = '{stt_pkg::EV_DONE, 8'h00,
                                    digits_reg ? stt_pkg::TT_INT : stt_pkg::TT_IDENT};
                    mode_next   = stt_pkg::MODE_IDLE;
                    digits_next = 1'b1;
                    do_idle     = 1'b1;
                end
                else
                begin
                    if (!b_digit)
                    begin
                        digits_next = 1'b0;
                    end
                    e0_v     = 1'b1;
                    h0       = '{stt_pkg::EV_TEXT, text_byte, stt_pkg::TT_NONE};
                    col_next = col_inc;
                end
            end
            stt_pkg::MODE_QUOTE:
            begin
                if (b_nul || b_nl)
                begin
                    e0_v      = 1'b1;
                    h0        = '{stt_pkg::EV_ERROR, 8'h00, q_type};
                    l0        = line_reg;
                    c0        = col_reg;
                    mode_next = stt_pkg::MODE_ERROR;
                    if (b_nul)
                    begin
                        line_next     = LINE_BITS'(1);
                        col_next      = '0;
                        tok_line_next = LINE_BITS'(1);
                        tok_col_next  = '0;
                        star_next     = 1'b0;
                        digits_next   = 1'b1;
                    end
                end
                else if (b_close)
                begin
                    e0_v      = 1'b1;
                    h0        = '{stt_pkg::EV_DONE, 8'h00, q_type};
                    col_next  = col_inc;
                    mode_next = stt_pkg::MODE_IDLE;
                end
                else
                begin
                    e0_v     = 1'b1;
                    h0       = '{stt_pkg::EV_TEXT, text_byte, stt_pkg::TT_NONE};
                    col_next = col_inc;
                end
            end
            default:
            begin
                // sticky error: only end of text touches the position
                mode_next = stt_pkg::MODE_ERROR;
                if (b_nul)
                begin
                    line_next     = LINE_BITS'(1);
                    col_next      = '0;
                    tok_line_next = LINE_BITS'(1);
                    tok_col_next  = '0;
                    star_next     = 1'b0;
                    digits_next   = 1'b1;
                end
            end
        endcase

        // Between-token handling, also reached after a flushed word or slash, and on end of text in a comment.
        if (do_idle)
        begin
            if (b_nul)
            begin
                line_next     = LINE_BITS'(1);
                col_next      = '0;
                tok_line_next = LINE_BITS'(1);
                tok_col_next  = '0;
                star_next     = 1'b0;
                digits_next   = 1'b1;
                mode_next     = stt_pkg::MODE_IDLE;
            end
            else if (b_nl)
            begin
                line_next = line_inc;
                col_next  = '0;
            end
            else if (text_byte == stt_pkg::CH_CR)
            begin
                col_next = col_reg;
            end
            else if (stt_pkg::is_space(text_byte))
            begin
                col_next = col_inc;
            end
            else if (text_byte == stt_pkg::CH_SLASH)
            begin
                tok_line_next = line_reg;
                tok_col_next  = col_reg;
                mode_next     = stt_pkg::MODE_SLASH;
                col_next      = col_inc;
            end
            else if (pn.hit)
            begin
                if (e0_v)
                begin
                    e1_v = 1'b1;
                    h1   = '{stt_pkg::EV_DONE, text_byte, pn.idx};
                    l1   = line_reg;
                    c1   = col_reg;
                end
                else
                begin
                    e0_v = 1'b1;
                    h0   = '{stt_pkg::EV_DONE, text_byte, pn.idx};
                    l0   = line_reg;
                    c0   = col_reg;
                end
                col_next = col_inc;
            end
            else if (b_quote)
            begin
                tok_line_next = line_reg;
                tok_col_next  = col_reg;
                single_next   = (text_byte == stt_pkg::CH_SQUOTE);
                mode_next     = stt_pkg::MODE_QUOTE;
                col_next      = col_inc;
            end
            else
            begin
                tok_line_next = line_reg;
                tok_col_next  = col_reg;
                digits_next   = b_digit;
                if (e0_v)
                begin
                    e1_v = 1'b1;
                    h1   = '{stt_pkg::EV_TEXT, text_byte, stt_pkg::TT_NONE};
                    l1   = line_reg;
                    c1   = col_reg;
                end
                else
                begin
                    e0_v = 1'b1;
                    h0   = '{stt_pkg::EV_TEXT, text_byte, stt_pkg::TT_NONE};
                    l0   = line_reg;
                    c0   = col_reg;
                end
                mode_next = stt_pkg::MODE_WORD;
                col_next  = col_inc;
            end
        end
    end

    assign push_valid = accept && e0_v;
    assign push_data  = {e1_v, h0, l0, c0, h1, l1, c1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= stt_pkg::MODE_IDLE;
            star_reg     <= 1'b0;
            single_reg   <= 1'b0;
            digits_reg   <= 1'b1;
            line_reg     <= LINE_BITS'(1);
            col_reg      <= '0;
            tok_line_reg <= LINE_BITS'(1);
            tok_col_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            star_reg     <= star_next;
            single_reg   <= single_next;
            digits_reg   <= digits_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
        end
    end

    // error mode is left only through reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == stt_pkg::MODE_ERROR) |=> (mode_reg == stt_pkg::MODE_ERROR))
        else $error("scanner left error mode");

    // a second result always follows a first one
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && e1_v) |-> e0_v)
        else $error("second result without first");

endmodule

### hdl/stt_queue.sv
// Short FIFO of result bundles between scanner front and output back.
module stt_queue #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    input  logic                 pop,
    output logic [DATA_BITS-1:0] pop_data,
    output stt_pkg::q_status_t   status
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] slot_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_BITS'(DEPTH));
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !status.full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> status.valid)
        else $error("pop from empty queue");

endmodule

### hdl/stt_back.sv
// Output back: unpacks a bundle and presents its one or two results in order.
module stt_back #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16,
    parameter int SLOT_BITS   = stt_pkg::HEAD_BITS + LINE_BITS + COLUMN_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  stt_pkg::q_status_t     q_status,
    input  logic [2*SLOT_BITS:0]   q_data,
    output logic                   q_pop,
    output logic                   event_valid,
    input  logic                   event_stall,
    output logic [1:0]             event_kind,
    output logic [7:0]             token_byte,
    output logic [4:0]             token_type,
    output logic [LINE_BITS-1:0]   start_line,
    output logic [COLUMN_BITS-1:0] start_column,
    output logic                   last_of_run
);

    logic [2*SLOT_BITS:0]  cur_reg;
    logic                  cur_valid_reg;
    logic                  idx_reg;
    logic                  two;
    logic                  out_accept;
    logic                  finish;
    logic [SLOT_BITS-1:0]  slot;
    stt_pkg::res_head_t    head;

    assign two        = cur_reg[2*SLOT_BITS];
    assign slot       = idx_reg ? cur_reg[SLOT_BITS-1:0] : cur_reg[2*SLOT_BITS-1 -: SLOT_BITS];
    assign head       = slot[SLOT_BITS-1 -: stt_pkg::HEAD_BITS];
    assign out_accept = event_valid && !event_stall;
    assign finish     = out_accept && last_of_run;
    assign q_pop      = q_status.valid && (!cur_valid_reg || finish);

    assign event_valid  = cur_valid_reg;
    assign event_kind   = head.kind;
    assign token_byte   = head.data;
    assign token_type   = head.ttype;
    assign start_line   = slot[LINE_BITS+COLUMN_BITS-1 -: LINE_BITS];
    assign start_column = slot[COLUMN_BITS-1:0];
    assign last_of_run  = !two || idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 1'b0;
        end
        else if (q_pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= 1'b0;
        end
        else if (finish)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 1'b0;
        end
        else if (out_accept)
        begin
            idx_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    // second slot is only shown for a two-result bundle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && idx_reg) |-> two)
        else $error("second result of single-result bundle");

endmodule

### hdl/source_text_tokenizer.sv
// Top level of the source text tokenizer: scanner front, bundle queue, output back.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  text    | in        | text_valid / text_stall    | text_byte
//  event   | out       | event_valid / event_stall  | event_kind, token_byte, token_type,
//          |           |                            | start_line, start_column, last_of_run
//
// One byte a cycle is taken while the queue is not full; the front scan state updates
// on each accepted byte. A byte gives zero, one or two results; the back sends one
// result a cycle while event_stall is low, so a run of two-result bytes is limited by
// the output port and fills the queue. Results pass the queue, then the output register.
// rst_n clears scan state, position to line 1 column 0, and empties the queue.
// text_stall rises only when the queue is full; event_stall holds the output register.
module source_text_tokenizer #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   text_valid,
    input  logic [7:0]             text_byte,
    output logic                   text_stall,
    output logic                   event_valid,
    input  logic                   event_stall,
    output logic [1:0]             event_kind,
    output logic [7:0]             token_byte,
    output logic [4:0]             token_type,
    output logic [LINE_BITS-1:0]   start_line,
    output logic [COLUMN_BITS-1:0] start_column,
    output logic                   last_of_run
);

    localparam int SLOT_BITS   = stt_pkg::HEAD_BITS + LINE_BITS + COLUMN_BITS;
    localparam int BUNDLE_BITS = 2 * SLOT_BITS + 1;

    logic                   push_valid;
    logic [BUNDLE_BITS-1:0] push_data;
    logic                   q_pop;
    logic [BUNDLE_BITS-1:0] q_data;
    stt_pkg::q_status_t     q_status;

    stt_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .SLOT_BITS   (SLOT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_byte  (text_byte),
        .text_stall (text_stall),
        .push_valid (push_valid),
        .push_data  (push_data),
        .q_status   (q_status)
    );

    stt_queue #(
        .DATA_BITS (BUNDLE_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    stt_back #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .SLOT_BITS   (SLOT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_kind   (event_kind),
        .token_byte   (token_byte),
        .token_type   (token_type),
        .start_line   (start_line),
        .start_column (start_column),
        .last_of_run  (last_of_run)
    );

endmodule
